// ----- rtl/core/bvs_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte vector store package
// Shared sizes, operation and result codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bvs_pkg;

   // Capacity of the store and the widths that follow from it.
   localparam int DEPTH  = 64;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int DATA_W = 8;
   localparam int POS_W  = 7;
   localparam int STS_W  = 2;

   // Position reported when a find does not succeed (minus one).
   localparam logic [POS_W-1:0] NO_POSITION = 7'h7F;

   // Requested operation.
   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_WRITE  = 3'd1,
      OP_READ   = 3'd2,
      OP_INSERT = 3'd3,
      OP_ERASE  = 3'd4,
      OP_POP    = 3'd5,
      OP_FIND   = 3'd6,
      OP_IGNORE = 3'd7
   } op_type;

   // Result status.
   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2,
      STS_MISS  = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request
      logic start;    // set up the walk pointer
      logic step;     // read one stored byte and move the pointer
      logic finish;   // commit the operation and register the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_needed;  // the operation has bytes to walk
      logic walk_last;    // the pointer is on the last byte of the walk
      logic found;        // a find has seen its first match
      logic rsp_busy;     // the result register is still held
   } sts_type;

endpackage

// ----- rtl/core/byte_vector_store_top.sv -----
// ----------------------------------------------------------------------------
// Byte vector store top level
// A fixed-capacity byte array with a fill count supporting append, write,
// read, insert, erase, remove-last and find.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  op, index, value
//   rsp_      out        rsp_valid/rsp_stall  status, read_data,
//                                             found_position, fill_count
//
// One request is processed at a time. Append, write, remove-last and rejected
// requests commit without walking the stored bytes; a read walks its one byte.
// Insert, erase and find walk the stored bytes through the single memory read
// port, one byte per cycle. A find stops at its first match.
// Reset clears the fill count and control state; the memory is not cleared.
// req_stall is high from a transfer until its result enters the output
// register; a result held by rsp_stall blocks only the commit of the next one.
module byte_vector_store_top
   import bvs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_op,
   input  logic [IDX_W-1:0]        req_index,
   input  logic [DATA_W-1:0]       req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STS_W-1:0]        rsp_status,
   output logic [DATA_W-1:0]       rsp_read_data,
   output logic signed [POS_W-1:0] rsp_found_position,
   output logic [CNT_W-1:0]        rsp_fill_count
);

   cmd_type cmd;
   sts_type sts;

   // Operation sequencer.
   bvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Memory, counters and result register.
   bvs_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_index          (req_index),
      .req_value          (req_value),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_found_position (rsp_found_position),
      .rsp_fill_count     (rsp_fill_count)
   );

endmodule

// ----- rtl/core/bvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Byte vector store controller
// Sequences one request at a time: capture, set-up, walk over the stored
// bytes, drain the last read, and commit once the result register is free.
// ----------------------------------------------------------------------------
module bvs_ctrl
   import bvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_WALK   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Requests are taken only while no operation is in progress.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = sts.walk_needed ? S_WALK : S_FINISH;
         end
         S_WALK: begin
            // A find stops walking as soon as it has a match.
            if (sts.found) begin
               state_in = S_FINISH;
            end else begin
               cmd.step = 1'b1;
               if (sts.walk_last) begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/bvs_dpath.sv -----
// ----------------------------------------------------------------------------
// Byte vector store datapath
// Holds the byte memory, the fill count, the walk pointer with its read
// pipeline, the find match and the registered result.
// ----------------------------------------------------------------------------
module bvs_dpath
   import bvs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [2:0]              req_op,
   input  logic [IDX_W-1:0]        req_index,
   input  logic [DATA_W-1:0]       req_value,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STS_W-1:0]        rsp_status,
   output logic [DATA_W-1:0]       rsp_read_data,
   output logic signed [POS_W-1:0] rsp_found_position,
   output logic [CNT_W-1:0]        rsp_fill_count
);

   // Captured request.
   op_type            op_ff;
   logic [IDX_W-1:0]  index_ff;
   logic [DATA_W-1:0] value_ff;

   // Fill count and walk state.
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [IDX_W-1:0]  ptr_ff;
   logic [IDX_W-1:0]  ptr_in;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  found_pos_ff;

   // Byte memory with a registered read port.
   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [DATA_W-1:0] mem_wdata;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_read_data_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   // Decoded checks on the captured request.
   logic [CNT_W-1:0]  idx_ext;
   logic              in_range;
   logic              full;
   logic [IDX_W-1:0]  last_idx;
   logic              hit;
   status_type        status;

   assign idx_ext  = {1'b0, index_ff};
   assign in_range = (idx_ext < count_ff);
   assign full     = (count_ff >= CNT_W'(DEPTH));
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign hit      = rd_valid_ff && (op_ff == OP_FIND) && !found_ff
                     && (rdata_ff == value_ff);

   // Walk range and direction for each operation.
   always_comb begin
      sts.walk_needed = 1'b0;
      sts.walk_last   = 1'b1;
      ptr_in          = ptr_ff;
      case (op_ff)
         OP_READ: begin
            sts.walk_needed = in_range;
            if (cmd.start) ptr_in = index_ff;
         end
         OP_INSERT: begin
            // Shift upwards from the top byte down to the index.
            sts.walk_needed = in_range && !full;
            sts.walk_last   = (ptr_ff == index_ff);
            if (cmd.start) ptr_in = last_idx;
            else if (cmd.step) ptr_in = ptr_ff - IDX_W'(1);
         end
         OP_ERASE: begin
            // Shift downwards from just above the index to the top byte.
            sts.walk_needed = (idx_ext + CNT_W'(1)) < count_ff;
            sts.walk_last   = (ptr_ff == last_idx);
            if (cmd.start) ptr_in = index_ff + IDX_W'(1);
            else if (cmd.step) ptr_in = ptr_ff + IDX_W'(1);
         end
         OP_FIND: begin
            sts.walk_needed = (count_ff != '0);
            sts.walk_last   = (ptr_ff == last_idx);
            if (cmd.start) ptr_in = '0;
            else if (cmd.step) ptr_in = ptr_ff + IDX_W'(1);
         end
         default: begin
            sts.walk_needed = 1'b0;
         end
      endcase
      sts.found    = found_ff;
      sts.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   // Memory write: a shift step from the read pipeline, or the final commit.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = index_ff;
      mem_wdata = value_ff;
      if (rd_valid_ff && (op_ff == OP_INSERT)) begin
         mem_we    = 1'b1;
         mem_waddr = rd_addr_ff + IDX_W'(1);
         mem_wdata = rdata_ff;
      end else if (rd_valid_ff && (op_ff == OP_ERASE)) begin
         mem_we    = 1'b1;
         mem_waddr = rd_addr_ff - IDX_W'(1);
         mem_wdata = rdata_ff;
      end else if (cmd.finish) begin
         case (op_ff)
            OP_APPEND: begin
               mem_we    = !full;
               mem_waddr = count_ff[IDX_W-1:0];
            end
            OP_WRITE:  mem_we = in_range;
            OP_INSERT: mem_we = !(idx_ext > count_ff) && !full;
            default:   mem_we = 1'b0;
         endcase
      end
   end

   // Status and new fill count of the operation.
   always_comb begin
      status   = STS_OK;
      count_in = count_ff;
      case (op_ff)
         OP_APPEND: begin
            if (full) status = STS_FULL;
            else count_in = count_ff + CNT_W'(1);
         end
         OP_WRITE, OP_READ: begin
            if (!in_range) status = STS_RANGE;
         end
         OP_INSERT: begin
            if (idx_ext > count_ff) status = STS_RANGE;
            else if (full) status = STS_FULL;
            else count_in = count_ff + CNT_W'(1);
         end
         OP_ERASE: begin
            if (!in_range) status = STS_RANGE;
            else count_in = count_ff - CNT_W'(1);
         end
         OP_POP: begin
            if (count_ff == '0) status = STS_MISS;
            else count_in = count_ff - CNT_W'(1);
         end
         OP_FIND: begin
            if (!found_ff) status = STS_MISS;
         end
         default: begin
            status = STS_OK;
         end
      endcase
   end

   // Memory array and its registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.step) begin
         rdata_ff <= store_ff[ptr_ff];
      end
   end

   // Request capture, walk pointer and match position.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_op);
         index_ff <= req_index;
         value_ff <= req_value;
      end
      ptr_ff <= ptr_in;
      if (cmd.step) begin
         rd_addr_ff <= ptr_ff;
      end
      if (hit) begin
         found_pos_ff <= rd_addr_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            count_ff <= count_in;
         end
         rd_valid_ff <= cmd.step;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (hit) begin
            found_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result register is loaded on commit and held while stalled.
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff    <= status;
         rsp_read_data_ff <= ((op_ff == OP_READ) && in_range) ? rdata_ff : '0;
         rsp_pos_ff       <= ((op_ff == OP_FIND) && found_ff)
                             ? {1'b0, found_pos_ff} : NO_POSITION;
         rsp_count_ff     <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_found_position = $signed(rsp_pos_ff);
   assign rsp_fill_count     = rsp_count_ff;

endmodule

// ----- rtl/core/bvs_checker.sv -----
// ----------------------------------------------------------------------------
// Byte vector store checker
// Port-level properties of the byte vector store, attached by a bind.
// ----------------------------------------------------------------------------
module bvs_checker
   import bvs_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [STS_W-1:0]        rsp_status,
   input logic [DATA_W-1:0]       rsp_read_data,
   input logic signed [POS_W-1:0] rsp_found_position,
   input logic [CNT_W-1:0]        rsp_fill_count
);

   // A held result keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_data) && $stable(rsp_found_position)
         && $stable(rsp_fill_count))
      else $error("result changed while stalled");

   // One request at a time: a transfer closes the input until it completes.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken during an operation");

   // The fill count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_count <= CNT_W'(DEPTH))
      else $error("fill count beyond capacity");

   // Read data is zero unless the operation succeeded.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_OK) |-> rsp_read_data == '0)
      else $error("read data on a failed operation");

   // A found position is reported only with a successful status.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_position != $signed(NO_POSITION))
         |-> rsp_status == STS_OK)
      else $error("position reported on a failed operation");

endmodule

bind byte_vector_store_top bvs_checker u_bvs_checker (.*);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Byte vector store testbench
// Drives append, write, read, insert, erase, remove-last and find requests
// into the store with random idling on both channels. A behavioural copy of
// the store in this file predicts every result, and each result transfer is
// checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
   import bvs_pkg::*;

   // One predicted result, with the operation that caused it.
   typedef struct {
      op_type              op;
      status_type          status;
      logic [DATA_W-1:0]   read_data;
      logic [POS_W-1:0]    found_position;
      logic [CNT_W-1:0]    fill_count;
   } store_result_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [2:0]              req_op = 3'd0;
   logic [IDX_W-1:0]        req_index = '0;
   logic [DATA_W-1:0]       req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STS_W-1:0]        rsp_status;
   logic [DATA_W-1:0]       rsp_read_data;
   logic signed [POS_W-1:0] rsp_found_position;
   logic [CNT_W-1:0]        rsp_fill_count;

   // Behavioural copy of the store contents and fill count.
   logic [DATA_W-1:0]   shadow_bytes [DEPTH];
   int                  shadow_count = 0;

   store_result_type    pending_results [$];
   int                  error_count = 0;

   // Idling controls for the stimulus and the receiver, and the fill target.
   bit                  tx_gaps = 1'b1;
   bit                  rx_gaps = 1'b1;
   int                  rx_hold_cycles = 0;
   int                  fill_target = DEPTH / 2;

   byte_vector_store_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_index          (req_index),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_read_data      (rsp_read_data),
      .rsp_found_position (rsp_found_position),
      .rsp_fill_count     (rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one request to the shadow store and return the result it gives.
   function automatic store_result_type apply_request(op_type op, logic [IDX_W-1:0] idx,
                                                      logic [DATA_W-1:0] val);
      store_result_type res;
      int               pos;
      int               j;
      pos = int'(idx);
      res.op             = op;
      res.status         = STS_OK;
      res.read_data      = '0;
      res.found_position = NO_POSITION;
      case (op)
         OP_APPEND: begin
            if (shadow_count >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               shadow_bytes[shadow_count] = val;
               shadow_count++;
            end
         end
         OP_WRITE: begin
            if (pos < shadow_count) shadow_bytes[pos] = val;
            else res.status = STS_RANGE;
         end
         OP_READ: begin
            if (pos < shadow_count) res.read_data = shadow_bytes[pos];
            else res.status = STS_RANGE;
         end
         OP_INSERT: begin
            // The range check comes before the full check.
            if (pos > shadow_count) begin
               res.status = STS_RANGE;
            end else if (shadow_count >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               for (j = shadow_count; j > pos; j--) shadow_bytes[j] = shadow_bytes[j-1];
               shadow_bytes[pos] = val;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (pos < shadow_count) begin
               for (j = pos; j + 1 < shadow_count; j++) shadow_bytes[j] = shadow_bytes[j+1];
               shadow_count--;
            end else begin
               res.status = STS_RANGE;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) res.status = STS_MISS;
            else shadow_count--;
         end
         OP_FIND: begin
            res.status = STS_MISS;
            for (j = 0; j < shadow_count; j++) begin
               if (shadow_bytes[j] == val) begin
                  res.found_position = POS_W'(j);
                  res.status         = STS_OK;
                  break;
               end
            end
         end
         default: begin
         end
      endcase
      res.fill_count = CNT_W'(shadow_count);
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   // Offer one request after a random gap and wait for its transfer.
   // Valid stays high afterwards so that back-to-back requests need no dip.
   task automatic send_request(op_type op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      int gap;
      gap = tx_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), apply_request(op, idx, val));
   endtask

   // Drop valid, wait for every outstanding result, then let the block settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Draw a request, steering the fill count towards the current target.
   task automatic pick_request(output op_type op, output logic [IDX_W-1:0] idx,
                               output logic [DATA_W-1:0] val);
      int  r;
      bit  grow;
      r    = $urandom_range(0, 99);
      grow = (shadow_count < fill_target);
      if (r < 2)       op = OP_IGNORE;
      else if (r < 16) op = OP_WRITE;
      else if (r < 32) op = OP_READ;
      else if (r < 46) op = OP_FIND;
      else if (r < 73) op = grow ? OP_APPEND : OP_ERASE;
      else             op = grow ? OP_INSERT : OP_POP;

      // Mostly legal positions, with some anywhere in the index range.
      if (shadow_count == 0 || $urandom_range(0, 99) < 12)
         idx = IDX_W'($urandom_range(0, DEPTH - 1));
      else if (op == OP_INSERT)
         idx = IDX_W'($urandom_range(0, (shadow_count > DEPTH - 1) ? DEPTH - 1
                                                                    : shadow_count));
      else
         idx = IDX_W'($urandom_range(0, shadow_count - 1));

      // Finds mostly look for a byte that is held.
      if (op == OP_FIND && shadow_count > 0 && $urandom_range(0, 9) < 7)
         val = shadow_bytes[$urandom_range(0, shadow_count - 1)];
      else
         val = DATA_W'($urandom_range(0, 255));
   endtask

   // Rejections on an empty store, then a few of each operation.
   task automatic test_directed_cases();
      send_request(OP_POP,    6'd0,  8'h00);
      send_request(OP_READ,   6'd0,  8'h00);
      send_request(OP_WRITE,  6'd0,  8'hFF);
      send_request(OP_ERASE,  6'd0,  8'h00);
      send_request(OP_FIND,   6'd0,  8'h00);
      send_request(OP_INSERT, 6'd1,  8'h11);
      send_request(OP_INSERT, 6'd0,  8'hFF);
      send_request(OP_APPEND, 6'd63, 8'h00);
      send_request(OP_APPEND, 6'd0,  8'hAA);
      send_request(OP_READ,   6'd0,  8'h00);
      send_request(OP_READ,   6'd1,  8'h00);
      send_request(OP_READ,   6'd2,  8'h00);
      send_request(OP_WRITE,  6'd2,  8'h55);
      send_request(OP_INSERT, 6'd1,  8'h3C);
      send_request(OP_INSERT, 6'd4,  8'hC3);
      send_request(OP_INSERT, 6'd63, 8'h01);
      send_request(OP_ERASE,  6'd0,  8'h00);
      send_request(OP_FIND,   6'd0,  8'h55);
      send_request(OP_FIND,   6'd0,  8'h99);
      send_request(OP_IGNORE, 6'd63, 8'hFF);
      send_request(OP_READ,   6'd63, 8'h00);
      send_request(OP_ERASE,  6'd3,  8'h00);
      send_request(OP_POP,    6'd0,  8'h00);
   endtask

   // Fill the store completely, exercise the full cases, then empty it.
   task automatic test_capacity_limits();
      while (shadow_count < DEPTH)
         send_request(OP_APPEND, IDX_W'($urandom_range(0, 63)),
                      DATA_W'($urandom_range(0, 255)));
      send_request(OP_APPEND, 6'd0,  8'h77);
      send_request(OP_INSERT, 6'd0,  8'h77);
      send_request(OP_INSERT, 6'd63, 8'h77);
      send_request(OP_READ,   6'd63, 8'h00);
      send_request(OP_WRITE,  6'd63, 8'hE7);
      send_request(OP_FIND,   6'd0,  8'hE7);
      send_request(OP_ERASE,  6'd0,  8'h00);
      send_request(OP_INSERT, 6'd0,  8'h5A);
      send_request(OP_ERASE,  6'd63, 8'h00);
      send_request(OP_INSERT, 6'd63, 8'hA5);
      send_request(OP_FIND,   6'd0,  8'hA5);
      while (shadow_count > 0)
         send_request(OP_POP, IDX_W'($urandom_range(0, 63)),
                      DATA_W'($urandom_range(0, 255)));
      send_request(OP_POP,    6'd0,  8'h00);
      send_request(OP_INSERT, 6'd63, 8'h00);
   endtask

   // Long random run; the fill target and the idling modes change as it goes.
   task automatic test_random_traffic();
      int                n;
      int                r;
      op_type            op;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] val;
      for (n = 0; n < 740; n++) begin
         if (n % 50 == 0) begin
            r = $urandom_range(0, 9);
            fill_target = (r < 2) ? 0 : (r < 4) ? DEPTH : $urandom_range(1, DEPTH - 1);
         end
         if (n % 120 == 0) begin
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
         end
         pick_request(op, idx, val);
         send_request(op, idx, val);
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_back_pressure();
      int                n;
      op_type            op;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] val;
      tx_gaps        = 1'b0;
      rx_gaps        = 1'b1;
      fill_target    = DEPTH / 2;
      rx_hold_cycles = 400;
      for (n = 0; n < 12; n++) begin
         pick_request(op, idx, val);
         send_request(op, idx, val);
      end
      tx_gaps = 1'b1;
   endtask

   // Result receiver: random stall before each transfer, or one long hold.
   initial begin : result_receiver
      int wait_cycles;
      @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (rx_hold_cycles) @(posedge clock);
            rx_hold_cycles = 0;
         end else begin
            wait_cycles = rx_gaps ? $urandom_range(0, 14) : 0;
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_cycles) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid && rx_hold_cycles == 0) @(posedge clock);
      end
   end

   // Compare each result transfer with the oldest prediction.
   always @(posedge clock) begin : result_check
      store_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transfer with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("%s status got %h expected %h",
                                         want.op.name(), rsp_status, want.status));
            if (rsp_read_data !== want.read_data)
               report_mismatch($sformatf("%s read_data got %h expected %h",
                                         want.op.name(), rsp_read_data, want.read_data));
            if (rsp_found_position !== want.found_position)
               report_mismatch($sformatf("%s found_position got %h expected %h",
                                         want.op.name(), rsp_found_position,
                                         want.found_position));
            if (rsp_fill_count !== want.fill_count)
               report_mismatch($sformatf("%s fill_count got %0d expected %0d",
                                         want.op.name(), rsp_fill_count, want.fill_count));
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : test_sequence
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_for_idle();
      test_capacity_limits();
      wait_for_idle();
      test_random_traffic();
      wait_for_idle();
      test_back_pressure();
      wait_for_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
